### hdl/assert_macros.svh
// Assertion macros for the fire alarm confirmation gate RTL.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: a concurrent assertion on a given clock and active-low reset.
`define FACG_ASSERT_IMPL(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Common form on the block clock and reset.
`define FACG_ASSERT(name, prop, msg) \
  `FACG_ASSERT_IMPL(name, clk_i, rst_ni, prop, msg)

`endif

### hdl/facg_pkg.sv
// Package for the fire alarm confirmation gate: word types, register codes,
// reset values and fixed-point thresholds. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package facg_pkg;

  // APB address width: six 32-bit registers at byte addresses 0 to 20.
  localparam int unsigned ApbAw = 5;

  typedef enum logic [2:0] {
    REG_CONFIRM_MS       = 3'd0,
    REG_RELEASE_MS       = 3'd1,
    REG_MIN_HITS         = 3'd2,
    REG_AMB_CONFIRM_MS   = 3'd3,
    REG_AMB_MIN_HITS     = 3'd4,
    REG_AMB_MIN_SCORE    = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_NORMAL    = 2'd0,
    STATUS_CANDIDATE = 2'd1,
    STATUS_CONFIRMED = 2'd2
  } alarm_status_e;

  // Register reset values.
  localparam logic [15:0] RstConfirmMs    = 16'd350;
  localparam logic [15:0] RstReleaseMs    = 16'd350;
  localparam logic [3:0]  RstMinHits      = 4'd2;
  localparam logic [15:0] RstAmbConfirmMs = 16'd900;
  localparam logic [3:0]  RstAmbMinHits   = 4'd3;
  localparam logic [9:0]  RstAmbMinScore  = 10'd780;

  // Per-mille and tenth-of-grey thresholds.
  localparam logic [9:0]  CandSkinMin  = 10'd350;
  localparam logic [9:0]  SurrSkinMin  = 10'd80;
  localparam logic [9:0]  YellowMin    = 10'd400;
  localparam logic [9:0]  RescueScore  = 10'd860;
  localparam logic [9:0]  RedOrangeMin = 10'd240;
  localparam logic [11:0] BrightMin    = 12'd28;
  localparam logic [9:0]  MaskMin      = 10'd40;
  localparam logic [9:0]  FingerScore  = 10'd900;

  // Candidate display threshold in percent of the active confirm time.
  localparam logic [6:0]  PctScale  = 7'd100;
  localparam logic [6:0]  PctWarm   = 7'd80;
  localparam logic [6:0]  PctNormal = 7'd65;

  // Bit positions in result_flags.
  localparam int unsigned RfNew    = 0;
  localparam int unsigned RfFresh  = 1;
  localparam int unsigned RfDet    = 2;
  localparam int unsigned RfBox    = 3;
  localparam int unsigned RfCand   = 4;
  localparam int unsigned RfAgeOk  = 5;

  // Bit positions in box_flags.
  localparam int unsigned BfRefl   = 0;
  localparam int unsigned BfFinger = 1;
  localparam int unsigned BfTiny   = 2;
  localparam int unsigned BfSkin   = 3;
  localparam int unsigned BfCore   = 4;
  localparam int unsigned BfStrong = 5;
  localparam int unsigned BfBright = 6;
  localparam int unsigned BfSep    = 7;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [5:0]  result_flags;
    logic [7:0]  box_flags;
    logic [9:0]  box_score;
    logic [9:0]  candidate_skin;
    logic [9:0]  surrounding_skin;
    logic [9:0]  yellow_ratio;
    logic [9:0]  red_orange;
    logic [9:0]  mask_change;
    logic [11:0] brightness_diff;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  alarm_status;
    logic [31:0] pending_ms;
    logic [7:0]  hit_count;
    logic        warm_risk;
  } out_word_t;

  typedef struct packed {
    logic [15:0] confirm_ms;
    logic [15:0] release_ms;
    logic [3:0]  min_hits;
    logic [15:0] amb_confirm_ms;
    logic [3:0]  amb_min_hits;
    logic [9:0]  amb_min_score;
  } cfg_t;

  // Verdict of the risk gates for one result.
  typedef struct packed {
    logic raw;
    logic warm;
  } gate_t;

  // What the tracker hands on to the status stage for one word.
  typedef struct packed {
    logic [31:0] pending_ms;
    logic [15:0] active_confirm;
    logic        active_warm;
    logic [7:0]  hits;
    logic        alarm_on;
    logic        hit_timing;
    logic        show_ok;
    logic        cand_ready;
  } track_t;

endpackage

`default_nettype wire

### hdl/facg_cfg.sv
// APB register file of the fire alarm confirmation gate.
// Depends on facg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module facg_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [facg_pkg::ApbAw-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output facg_pkg::cfg_t                   cfg_o
);

  facg_pkg::cfg_t     cfg_q;
  facg_pkg::cfg_t     cfg_d;
  facg_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = facg_pkg::reg_idx_e'(paddr[facg_pkg::ApbAw-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        facg_pkg::REG_CONFIRM_MS:     cfg_d.confirm_ms     = pwdata[15:0];
        facg_pkg::REG_RELEASE_MS:     cfg_d.release_ms     = pwdata[15:0];
        facg_pkg::REG_MIN_HITS:       cfg_d.min_hits       = pwdata[3:0];
        facg_pkg::REG_AMB_CONFIRM_MS: cfg_d.amb_confirm_ms = pwdata[15:0];
        facg_pkg::REG_AMB_MIN_HITS:   cfg_d.amb_min_hits   = pwdata[3:0];
        facg_pkg::REG_AMB_MIN_SCORE:  cfg_d.amb_min_score  = pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      facg_pkg::REG_CONFIRM_MS:     prdata = {16'd0, cfg_q.confirm_ms};
      facg_pkg::REG_RELEASE_MS:     prdata = {16'd0, cfg_q.release_ms};
      facg_pkg::REG_MIN_HITS:       prdata = {28'd0, cfg_q.min_hits};
      facg_pkg::REG_AMB_CONFIRM_MS: prdata = {16'd0, cfg_q.amb_confirm_ms};
      facg_pkg::REG_AMB_MIN_HITS:   prdata = {28'd0, cfg_q.amb_min_hits};
      facg_pkg::REG_AMB_MIN_SCORE:  prdata = {22'd0, cfg_q.amb_min_score};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_ms     <= facg_pkg::RstConfirmMs;
      cfg_q.release_ms     <= facg_pkg::RstReleaseMs;
      cfg_q.min_hits       <= facg_pkg::RstMinHits;
      cfg_q.amb_confirm_ms <= facg_pkg::RstAmbConfirmMs;
      cfg_q.amb_min_hits   <= facg_pkg::RstAmbMinHits;
      cfg_q.amb_min_score  <= facg_pkg::RstAmbMinScore;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/facg_gate.sv
// Risk classification and score gates for the first detection box.
// Purely combinational; depends on facg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module facg_gate (
  input  facg_pkg::in_word_t   word_i,
  input  wire logic [9:0]      amb_min_score_i,
  output facg_pkg::gate_t      gate_o
);

  logic has_box, refl, finger, skin, warm, rescue;
  logic pass_refl, pass_finger, pass_risk;
  logic f_core, f_strong;

  assign has_box  = word_i.result_flags[facg_pkg::RfBox];
  assign f_core   = word_i.box_flags[facg_pkg::BfCore];
  assign f_strong = word_i.box_flags[facg_pkg::BfStrong];

  assign refl   = has_box && word_i.box_flags[facg_pkg::BfRefl];
  assign finger = has_box && word_i.box_flags[facg_pkg::BfFinger];
  assign skin   = has_box && word_i.box_flags[facg_pkg::BfTiny] &&
                  (word_i.box_flags[facg_pkg::BfSkin] ||
                   (word_i.candidate_skin >= facg_pkg::CandSkinMin &&
                    word_i.surrounding_skin >= facg_pkg::SurrSkinMin));
  assign warm   = has_box && (finger || (!f_core && (refl || skin ||
                  word_i.yellow_ratio >= facg_pkg::YellowMin)));

  // A reflection may still pass when a very confident, red-orange box flickers.
  assign rescue = refl && word_i.box_score >= facg_pkg::RescueScore &&
                  word_i.red_orange >= facg_pkg::RedOrangeMin &&
                  (word_i.brightness_diff >= facg_pkg::BrightMin ||
                   word_i.mask_change >= facg_pkg::MaskMin);

  assign pass_refl   = has_box && (!refl || (f_strong && (f_core ||
                       word_i.box_flags[facg_pkg::BfBright] || rescue)));
  assign pass_finger = has_box && (!finger || (word_i.box_score >= facg_pkg::FingerScore &&
                       f_strong && word_i.box_flags[facg_pkg::BfSep]));
  assign pass_risk   = has_box && pass_refl && pass_finger &&
                       (!warm || (word_i.box_score >= amb_min_score_i && f_strong));

  assign gate_o.warm = warm;
  assign gate_o.raw  = word_i.result_flags[facg_pkg::RfFresh] &&
                       word_i.result_flags[facg_pkg::RfDet] && has_box && pass_risk;

endmodule

`default_nettype wire

### hdl/facg_track.sv
// Hit and loss timing, confirmation and release state of the alarm.
// Depends on facg_pkg; the state advances once for each stepped word.
`timescale 1ns / 1ps
`default_nettype none

module facg_track (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  facg_pkg::in_word_t  word_i,
  input  facg_pkg::gate_t     gate_i,
  input  facg_pkg::cfg_t      cfg_i,
  output facg_pkg::track_t    track_o
);

  logic        alarm_on_q, alarm_on_d;
  logic        hit_timing_q, hit_timing_d;
  logic        loss_timing_q, loss_timing_d;
  logic [7:0]  hits_q, hits_d;
  logic [31:0] hit_start_q, hit_start_d;
  logic [31:0] loss_start_q, loss_start_d;
  logic [15:0] act_confirm_q, act_confirm_d;
  logic [3:0]  act_min_hits_q, act_min_hits_d;
  logic        act_warm_q, act_warm_d;
  logic [31:0] pending;
  logic        fresh;

  assign fresh = word_i.result_flags[facg_pkg::RfFresh];

  always_comb begin
    logic [15:0] need_ms;
    logic [3:0]  need_hits;
    logic [31:0] lost;
    logic        clear;

    alarm_on_d     = alarm_on_q;
    hit_timing_d   = hit_timing_q;
    loss_timing_d  = loss_timing_q;
    hits_d         = hits_q;
    hit_start_d    = hit_start_q;
    loss_start_d   = loss_start_q;
    act_confirm_d  = act_confirm_q;
    act_min_hits_d = act_min_hits_q;
    act_warm_d     = act_warm_q;
    pending        = 32'd0;
    need_ms   = gate_i.warm ? cfg_i.amb_confirm_ms : cfg_i.confirm_ms;
    need_hits = gate_i.warm ? cfg_i.amb_min_hits : cfg_i.min_hits;

    if (word_i.result_flags[facg_pkg::RfNew]) begin
      if (gate_i.raw) begin
        if (!hit_timing_q) begin
          hit_timing_d   = 1'b1;
          hit_start_d    = word_i.time_ms;
          hits_d         = 8'd1;
          act_confirm_d  = need_ms;
          act_min_hits_d = need_hits;
          act_warm_d     = gate_i.warm;
        end else begin
          if (hits_q != 8'hFF) begin
            hits_d = hits_q + 8'd1;
          end
          if (need_ms > act_confirm_q) begin
            act_confirm_d = need_ms;
          end
          if (need_hits > act_min_hits_q) begin
            act_min_hits_d = need_hits;
          end
          act_warm_d = act_warm_q || gate_i.warm;
        end
        loss_timing_d = 1'b0;
      end else if (!alarm_on_q) begin
        hit_timing_d   = 1'b0;
        hits_d         = 8'd0;
        act_confirm_d  = cfg_i.confirm_ms;
        act_min_hits_d = cfg_i.min_hits;
        act_warm_d     = 1'b0;
      end else if (!loss_timing_q) begin
        loss_timing_d = 1'b1;
        loss_start_d  = word_i.time_ms;
      end
    end

    if (hit_timing_d) begin
      pending = word_i.time_ms - hit_start_d;
    end

    if (!alarm_on_d && hit_timing_d && hits_d >= {4'd0, act_min_hits_d} &&
        pending >= {16'd0, act_confirm_d}) begin
      alarm_on_d    = 1'b1;
      loss_timing_d = 1'b0;
    end

    lost  = word_i.time_ms - loss_start_d;
    clear = !fresh || (alarm_on_d && loss_timing_d && lost >= {16'd0, cfg_i.release_ms});

    if (clear) begin
      alarm_on_d     = 1'b0;
      hit_timing_d   = 1'b0;
      loss_timing_d  = 1'b0;
      hits_d         = 8'd0;
      act_confirm_d  = cfg_i.confirm_ms;
      act_min_hits_d = cfg_i.min_hits;
      act_warm_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_on_q     <= 1'b0;
      hit_timing_q   <= 1'b0;
      loss_timing_q  <= 1'b0;
      hits_q         <= 8'd0;
      hit_start_q    <= 32'd0;
      loss_start_q   <= 32'd0;
      act_confirm_q  <= facg_pkg::RstConfirmMs;
      act_min_hits_q <= facg_pkg::RstMinHits;
      act_warm_q     <= 1'b0;
    end else if (step_i) begin
      alarm_on_q     <= alarm_on_d;
      hit_timing_q   <= hit_timing_d;
      loss_timing_q  <= loss_timing_d;
      hits_q         <= hits_d;
      hit_start_q    <= hit_start_d;
      loss_start_q   <= loss_start_d;
      act_confirm_q  <= act_confirm_d;
      act_min_hits_q <= act_min_hits_d;
      act_warm_q     <= act_warm_d;
    end
  end

  assign track_o.pending_ms     = pending;
  assign track_o.active_confirm = act_confirm_d;
  assign track_o.active_warm    = act_warm_d;
  assign track_o.hits           = hits_d;
  assign track_o.alarm_on       = alarm_on_d;
  assign track_o.hit_timing     = hit_timing_d;
  assign track_o.show_ok        = fresh && word_i.result_flags[facg_pkg::RfAgeOk];
  assign track_o.cand_ready     = word_i.result_flags[facg_pkg::RfCand];

endmodule

`default_nettype wire

### hdl/fire_alarm_confirm_gate_core.sv
// Fire alarm confirmation gate, top level: input, track and output stages.
// Depends on facg_pkg, facg_cfg, facg_gate, facg_track and assert_macros.svh.
//
// The block takes one word per display tick and returns one result word for
// each, in order. A word can be accepted in every clock cycle unless every
// stage is full and stalled; each result passes the input, track and output
// registers. facg_track updates the alarm state for one word per cycle,
// unless stalled, between the input and track registers; the candidate
// threshold multiply sits in the last stage on its own. Each stage holds its
// word while the next cannot move, so input is still taken while a result
// waits at the output until the stages fill. Registers are to be written
// over APB only while no word is in flight; the block does not check this.
// confirm_ms and min_hits also seed the active values of the next hit cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fire_alarm_confirm_gate_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  facg_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output facg_pkg::out_word_t              out_word_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [facg_pkg::ApbAw-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  facg_pkg::cfg_t     cfg;
  facg_pkg::gate_t    gate;
  facg_pkg::track_t   track;

  // Stage registers: input word, tracked state snapshot, output word.
  facg_pkg::in_word_t  in_word_q;
  logic                in_valid_q;
  facg_pkg::track_t    track_q;
  logic                track_valid_q;
  facg_pkg::out_word_t out_word_q, out_word_d;
  logic                out_valid_q;

  logic out_adv, track_adv, in_adv, in_acc, step;

  // Each stage moves when it is empty or the stage after it moves.
  assign out_adv   = !out_valid_q || out_ready_i;
  assign track_adv = !track_valid_q || out_adv;
  assign in_adv    = !in_valid_q || track_adv;
  assign in_ready_o = in_adv;
  assign in_acc    = in_valid_i && in_adv;
  assign step      = in_valid_q && track_adv;

  facg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  facg_gate u_gate (
    .word_i          (in_word_q),
    .amb_min_score_i (cfg.amb_min_score),
    .gate_o          (gate)
  );

  facg_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .word_i  (in_word_q),
    .gate_i  (gate),
    .cfg_i   (cfg),
    .track_o (track)
  );

  // Status: confirmed wins; otherwise a fresh, young enough box shows as a
  // candidate when the detector says so or the hit time has reached the
  // display share of the active confirm time (80 percent when warm, else 65).
  always_comb begin
    logic [38:0] pend_scaled;
    logic [38:0] conf_scaled;

    pend_scaled = 39'(track_q.pending_ms) * 39'(facg_pkg::PctScale);
    conf_scaled = 39'(track_q.active_confirm) *
                  39'(track_q.active_warm ? facg_pkg::PctWarm : facg_pkg::PctNormal);

    if (track_q.alarm_on) begin
      out_word_d.alarm_status = facg_pkg::STATUS_CONFIRMED;
    end else if (track_q.show_ok && (track_q.cand_ready ||
                 (track_q.hit_timing && pend_scaled >= conf_scaled))) begin
      out_word_d.alarm_status = facg_pkg::STATUS_CANDIDATE;
    end else begin
      out_word_d.alarm_status = facg_pkg::STATUS_NORMAL;
    end
    out_word_d.pending_ms = track_q.pending_ms;
    out_word_d.hit_count  = track_q.hits;
    out_word_d.warm_risk  = track_q.active_warm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      track_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (track_adv) begin
        track_valid_q <= in_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= track_valid_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_word_q <= in_word_i;
    end
    if (step) begin
      track_q <= track;
    end
    if (out_adv && track_valid_q) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // An accepted word always lands in the input stage.
  `FACG_ASSERT(a_accept_lands, in_acc |=> in_valid_q, "accepted word lost at input stage")
  // A tracked word that cannot move on is kept.
  `FACG_ASSERT(a_track_holds, (track_valid_q && !out_adv) |=> track_valid_q, "tracked word dropped")
  // A confirmed alarm always rests on at least one counted hit.
  `FACG_ASSERT(a_confirm_hits, (out_valid_q && out_word_q.alarm_status == facg_pkg::STATUS_CONFIRMED) |-> (out_word_q.hit_count != 8'd0), "confirmed alarm without hits")
  // The warm rule is only latched inside a hit cycle.
  `FACG_ASSERT(a_warm_hits, (out_valid_q && out_word_q.warm_risk) |-> (out_word_q.hit_count != 8'd0), "warm risk without hits")

endmodule

`default_nettype wire

### test/facg_tb_pkg.sv
// Checker class for the fire alarm confirmation gate testbench: it tracks the
// alarm state word by word and compares each result word. Depends on facg_pkg.
`timescale 1ns / 1ps

package facg_tb_pkg;

  import facg_pkg::*;

  class alarm_gate_checker;

    // Registers as last written.
    logic [15:0] cfg_confirm;
    logic [15:0] cfg_release;
    logic [3:0]  cfg_min_hits;
    logic [15:0] cfg_amb_confirm;
    logic [3:0]  cfg_amb_min_hits;
    logic [9:0]  cfg_amb_score;

    // Alarm tracking state.
    bit          alarm_on;
    bit          hit_timing;
    bit          loss_timing;
    bit          warm_latched;
    logic [7:0]  hit_cnt;
    logic [31:0] hit_start;
    logic [31:0] loss_start;
    logic [15:0] act_confirm;
    logic [3:0]  act_min_hits;

    out_word_t   expected_alarms[$];

    int unsigned errors;
    int unsigned n_words;
    int unsigned n_results;
    int unsigned n_confirmed;
    int unsigned n_candidate;
    int unsigned n_warm;
    int unsigned n_full;

    function new();
      cfg_confirm      = RstConfirmMs;
      cfg_release      = RstReleaseMs;
      cfg_min_hits     = RstMinHits;
      cfg_amb_confirm  = RstAmbConfirmMs;
      cfg_amb_min_hits = RstAmbMinHits;
      cfg_amb_score    = RstAmbMinScore;
      hit_start        = '0;
      loss_start       = '0;
      restart_cycle();
    endfunction

    // Drops the current alarm cycle and reloads the active values.
    function void restart_cycle();
      alarm_on     = 1'b0;
      hit_timing   = 1'b0;
      loss_timing  = 1'b0;
      hit_cnt      = '0;
      act_confirm  = cfg_confirm;
      act_min_hits = cfg_min_hits;
      warm_latched = 1'b0;
    endfunction

    function void write_register(int unsigned idx, logic [31:0] value);
      case (idx)
        REG_CONFIRM_MS:     cfg_confirm      = value[15:0];
        REG_RELEASE_MS:     cfg_release      = value[15:0];
        REG_MIN_HITS:       cfg_min_hits     = value[3:0];
        REG_AMB_CONFIRM_MS: cfg_amb_confirm  = value[15:0];
        REG_AMB_MIN_HITS:   cfg_amb_min_hits = value[3:0];
        REG_AMB_MIN_SCORE:  cfg_amb_score    = value[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_alarms.size();
    endfunction

    // Advances the alarm state by one accepted word and queues its result.
    function void note_word(in_word_t w);
      bit               is_new, fresh, det, box, cand, age_ok;
      bit               refl, finger, skin, warm, rescue;
      bit               pass_refl, pass_finger, pass_risk, raw;
      bit [7:0]         bf;
      logic [15:0]      need_ms;
      logic [3:0]       need_hits;
      logic [31:0]      pend;
      logic [31:0]      lost;
      longint unsigned  lhs, rhs;
      out_word_t        exp_word;

      is_new = w.result_flags[RfNew];
      fresh  = w.result_flags[RfFresh];
      det    = w.result_flags[RfDet];
      box    = w.result_flags[RfBox];
      cand   = w.result_flags[RfCand];
      age_ok = w.result_flags[RfAgeOk];
      bf     = w.box_flags;

      refl   = box && bf[BfRefl];
      finger = box && bf[BfFinger];
      skin   = box && bf[BfTiny] && (bf[BfSkin] ||
               (w.candidate_skin >= CandSkinMin && w.surrounding_skin >= SurrSkinMin));
      warm   = box && (finger || (!bf[BfCore] && (refl || skin || w.yellow_ratio >= YellowMin)));
      rescue = refl && w.box_score >= RescueScore && w.red_orange >= RedOrangeMin &&
               (w.brightness_diff >= BrightMin || w.mask_change >= MaskMin);
      pass_refl   = box && (!refl || (bf[BfStrong] && (bf[BfCore] || bf[BfBright] || rescue)));
      pass_finger = box && (!finger || (w.box_score >= FingerScore && bf[BfStrong] && bf[BfSep]));
      pass_risk   = box && pass_refl && pass_finger &&
                    (!warm || (w.box_score >= cfg_amb_score && bf[BfStrong]));
      raw         = fresh && det && box && pass_risk;

      if (is_new) begin
        if (raw) begin
          need_ms   = warm ? cfg_amb_confirm : cfg_confirm;
          need_hits = warm ? cfg_amb_min_hits : cfg_min_hits;
          if (!hit_timing) begin
            hit_timing   = 1'b1;
            hit_start    = w.time_ms;
            hit_cnt      = 8'd1;
            act_confirm  = need_ms;
            act_min_hits = need_hits;
            warm_latched = warm;
          end else begin
            if (hit_cnt != 8'hFF) hit_cnt = hit_cnt + 8'd1;
            if (need_ms > act_confirm) act_confirm = need_ms;
            if (need_hits > act_min_hits) act_min_hits = need_hits;
            warm_latched = warm_latched || warm;
          end
          loss_timing = 1'b0;
        end else if (!alarm_on) begin
          hit_timing   = 1'b0;
          hit_cnt      = '0;
          act_confirm  = cfg_confirm;
          act_min_hits = cfg_min_hits;
          warm_latched = 1'b0;
        end else if (!loss_timing) begin
          loss_timing = 1'b1;
          loss_start  = w.time_ms;
        end
      end

      pend = hit_timing ? w.time_ms - hit_start : 32'd0;

      if (!alarm_on && hit_timing && hit_cnt >= act_min_hits && pend >= act_confirm) begin
        alarm_on    = 1'b1;
        loss_timing = 1'b0;
      end

      if (alarm_on && loss_timing) begin
        lost = w.time_ms - loss_start;
        if (lost >= cfg_release) restart_cycle();
      end

      if (!fresh) restart_cycle();

      lhs = pend;
      lhs = lhs * PctScale;
      rhs = act_confirm;
      rhs = rhs * (warm_latched ? PctWarm : PctNormal);

      if (alarm_on) begin
        exp_word.alarm_status = STATUS_CONFIRMED;
      end else if (fresh && age_ok && (cand || (hit_timing && lhs >= rhs))) begin
        exp_word.alarm_status = STATUS_CANDIDATE;
      end else begin
        exp_word.alarm_status = STATUS_NORMAL;
      end
      exp_word.pending_ms = pend;
      exp_word.hit_count  = hit_cnt;
      exp_word.warm_risk  = warm_latched;

      expected_alarms.push_back(exp_word);
      n_words++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_result(out_word_t got);
      out_word_t exp_word;
      n_results++;
      if (expected_alarms.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      exp_word = expected_alarms.pop_front();
      compare_field("alarm_status", exp_word.alarm_status, got.alarm_status);
      compare_field("pending_ms", exp_word.pending_ms, got.pending_ms);
      compare_field("hit_count", exp_word.hit_count, got.hit_count);
      compare_field("warm_risk", exp_word.warm_risk, got.warm_risk);
      if (exp_word.alarm_status == STATUS_CONFIRMED) n_confirmed++;
      if (exp_word.alarm_status == STATUS_CANDIDATE) n_candidate++;
      if (exp_word.warm_risk) n_warm++;
      if (exp_word.hit_count == 8'hFF) n_full++;
    endfunction

  endclass

endpackage

### test/tb_fire_alarm_confirm_gate_core.sv
// Testbench top for fire_alarm_confirm_gate_core: directed and random words,
// APB register settings, random idling on both sides. Depends on facg_pkg,
// facg_tb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_fire_alarm_confirm_gate_core;

  import facg_pkg::*;
  import facg_tb_pkg::*;

  // Kinds of random bursts. Steady bursts are clean fire hits that never
  // fail a gate, used to run the hit count up to saturation.
  typedef enum int {
    BURST_FIRE,
    BURST_WARM,
    BURST_QUIET,
    BURST_NOISE,
    BURST_STEADY
  } burst_e;

  // Flag masks for the directed words.
  localparam logic [5:0] F_NEW   = 6'b1 << RfNew;
  localparam logic [5:0] F_FRESH = 6'b1 << RfFresh;
  localparam logic [5:0] F_DET   = 6'b1 << RfDet;
  localparam logic [5:0] F_BOX   = 6'b1 << RfBox;
  localparam logic [5:0] F_CAND  = 6'b1 << RfCand;
  localparam logic [5:0] F_AGE   = 6'b1 << RfAgeOk;
  localparam logic [5:0] F_HIT   = F_NEW | F_FRESH | F_DET | F_BOX;

  localparam logic [7:0] B_REFL   = 8'b1 << BfRefl;
  localparam logic [7:0] B_FINGER = 8'b1 << BfFinger;
  localparam logic [7:0] B_TINY   = 8'b1 << BfTiny;
  localparam logic [7:0] B_SKIN   = 8'b1 << BfSkin;
  localparam logic [7:0] B_CORE   = 8'b1 << BfCore;
  localparam logic [7:0] B_STRONG = 8'b1 << BfStrong;
  localparam logic [7:0] B_SEP    = 8'b1 << BfSep;

  // Register index just past the last register; writes there are ignored.
  localparam int unsigned UnusedRegIdx = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_word;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ApbAw-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  alarm_gate_checker  sb = new();

  // Receiver idling: percentage of cycles with ready low, and a request for a
  // long hold-off that the receiver process counts out on its own.
  int unsigned        rx_idle_pct = 74;
  logic               hold_req = 1'b0;
  int unsigned        hold_left = 0;

  // Running tick time for the random words.
  logic [31:0]        tick = '0;

  fire_alarm_confirm_gate_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A generous fixed limit; a correct run ends long before it.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Both handshakes are observed at the rising edge, on the values that held
  // just before it. An input word is noted before the result check so that
  // even a result in the same cycle would find its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_word);
      if (out_valid && out_ready) sb.check_result(out_word);
    end
  end

  // Receiver. A pending hold-off request keeps ready low for a long stretch,
  // during which the sender keeps offering words so the pipeline fills up.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 150;
      hold_req <= 1'b0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic in_word_t mk_word(logic [31:0] t, logic [5:0] rf, logic [7:0] bf,
                                       int unsigned score, int unsigned yellow);
    in_word_t w;
    w = '0;
    w.time_ms      = t;
    w.result_flags = rf;
    w.box_flags    = bf;
    w.box_score    = 10'(score);
    w.yellow_ratio = 10'(yellow);
    return w;
  endfunction

  // A value within a few counts of a threshold, clamped to the field range.
  function automatic int near_threshold(int center, int hi);
    int v;
    v = center + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Builds one random word of the given burst kind and advances the tick.
  // Most words are plausible frames a few tens of milliseconds apart; now and
  // then the time jumps, and noise words leave every field fully random.
  function automatic in_word_t gen_word(burst_e kind);
    in_word_t    w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) tick = $urandom;
    else if (r < 5) tick = tick + $urandom_range(70000);
    else tick = tick + $urandom_range(80);

    w.time_ms          = tick;
    w.result_flags     = 6'($urandom);
    w.box_flags        = 8'($urandom);
    w.box_score        = 10'($urandom_range(1000));
    w.candidate_skin   = 10'($urandom_range(1000));
    w.surrounding_skin = 10'($urandom_range(1000));
    w.yellow_ratio     = 10'($urandom_range(1000));
    w.red_orange       = 10'($urandom_range(1000));
    w.mask_change      = 10'($urandom_range(1000));
    w.brightness_diff  = 12'($urandom_range(2550));

    if (kind != BURST_NOISE) begin
      w.result_flags[RfNew]   = ($urandom_range(9) != 0);
      w.result_flags[RfFresh] = ($urandom_range(39) != 0);
      w.result_flags[RfDet]   = (kind == BURST_QUIET) ? ($urandom_range(4) == 0)
                                                      : ($urandom_range(19) != 0);
      w.result_flags[RfBox]   = ($urandom_range(19) != 0);
      w.result_flags[RfCand]  = ($urandom_range(4) == 0);
      w.box_flags[BfRefl]     = ($urandom_range(7) == 0);
      w.box_flags[BfFinger]   = ($urandom_range(9) == 0);
      w.box_flags[BfTiny]     = ($urandom_range(5) == 0);
      w.box_flags[BfStrong]   = ($urandom_range(9) != 0);
      w.box_flags[BfCore]     = (kind == BURST_WARM) ? 1'b0 : ($urandom_range(9) < 7);
      if (kind == BURST_WARM) w.yellow_ratio = 10'(near_threshold(YellowMin, 1000));
      else w.yellow_ratio = 10'($urandom_range(450));
      case ($urandom_range(3))
        0: w.box_score = 10'(near_threshold(RescueScore, 1000));
        1: w.box_score = 10'(near_threshold(FingerScore, 1000));
        2: w.box_score = 10'(near_threshold(sb.cfg_amb_score, 1000));
        default: w.box_score = 10'($urandom_range(650, 1000));
      endcase
      if ($urandom_range(2) == 0) w.red_orange = 10'(near_threshold(RedOrangeMin, 1000));
      if ($urandom_range(2) == 0) w.brightness_diff = 12'(near_threshold(BrightMin, 2550));
      if ($urandom_range(2) == 0) w.mask_change = 10'(near_threshold(MaskMin, 1000));
      if ($urandom_range(2) == 0) w.candidate_skin = 10'(near_threshold(CandSkinMin, 1000));
      if ($urandom_range(2) == 0) w.surrounding_skin = 10'(near_threshold(SurrSkinMin, 1000));
    end

    if (kind == BURST_STEADY) begin
      w.result_flags[RfNew]   = 1'b1;
      w.result_flags[RfFresh] = 1'b1;
      w.result_flags[RfDet]   = 1'b1;
      w.result_flags[RfBox]   = 1'b1;
      w.box_flags[BfRefl]     = 1'b0;
      w.box_flags[BfFinger]   = 1'b0;
      w.box_flags[BfCore]     = 1'b1;
      w.box_flags[BfStrong]   = 1'b1;
    end
    return w;
  endfunction

  // Offers one word and holds it until accepted. Valid stays high into the
  // next word unless a random gap follows, so it is never lowered and raised
  // in the same time step. Called at a rising edge.
  task automatic send_word(in_word_t w, int unsigned gap_pct);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    while (gap < 30 && $urandom_range(99) < gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected result word has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // One APB write: setup cycle, access cycle, then an idle wait so that the
  // next write never changes psel twice in one time step.
  task automatic reg_write(int unsigned idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAw'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
    @(posedge clk);
  endtask

  task automatic set_config(int unsigned conf, int unsigned rel, int unsigned mh,
                            int unsigned aconf, int unsigned amh, int unsigned ascore);
    reg_write(REG_CONFIRM_MS, conf);
    reg_write(REG_RELEASE_MS, rel);
    reg_write(REG_MIN_HITS, mh);
    reg_write(REG_AMB_CONFIRM_MS, aconf);
    reg_write(REG_AMB_MIN_HITS, amh);
    reg_write(REG_AMB_MIN_SCORE, ascore);
  endtask

  // Random words in bursts of one kind. Fire bursts dominate so that hit
  // cycles build up, confirm and get released; quiet bursts drive the loss
  // timing and noise covers everything else. With a hold-off the first words
  // go out without gaps while the receiver is held.
  task automatic run_phase(int unsigned n, int unsigned tx_pct, int unsigned rx_pct, bit hold);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    burst_e      kind;
    sent = 0;
    rx_idle_pct <= rx_pct;
    if (hold) hold_req <= 1'b1;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 45) kind = BURST_FIRE;
      else if (r < 65) kind = BURST_WARM;
      else if (r < 88) kind = BURST_QUIET;
      else kind = BURST_NOISE;
      len = $urandom_range(3, 25);
      for (int unsigned i = 0; i < len && sent < n; i++) begin
        send_word(gen_word(kind), (hold && sent < 60) ? 0 : tx_pct);
        sent++;
      end
    end
  endtask

  initial begin
    in_word_t    w;
    int unsigned c;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with the reset register values. They walk through the
    // corners first: all-zero and all-maximum words, a missing box, a normal
    // confirm and release, the ambiguous warm rules, reflection and finger
    // gates, skin by ratios, candidate display, time wrap and staleness.
    send_word(mk_word(32'd0, '0, '0, 0, 0), 21);
    w = mk_word('1, '1, '1, 1000, 1000);
    w.candidate_skin   = 10'd1000;
    w.surrounding_skin = 10'd1000;
    w.red_orange       = 10'd1000;
    w.mask_change      = 10'd1000;
    w.brightness_diff  = 12'd2550;
    send_word(w, 21);
    send_word(mk_word(32'd100, F_HIT & ~F_BOX, B_CORE | B_STRONG, 900, 0), 21);

    // Normal cycle: two hits and enough time confirm; a no-new word between
    // them only runs the timing and shows the candidate status.
    send_word(mk_word(32'd1000, F_HIT, B_CORE | B_STRONG, 500, 0), 21);
    send_word(mk_word(32'd1100, F_HIT | F_AGE, B_CORE | B_STRONG, 500, 0), 21);
    send_word(mk_word(32'd1250, F_FRESH | F_AGE, '0, 0, 0), 21);
    send_word(mk_word(32'd1400, F_HIT, B_CORE | B_STRONG, 500, 0), 21);

    // Loss: undetected results start the loss timer, which then releases.
    send_word(mk_word(32'd1500, F_NEW | F_FRESH, '0, 0, 0), 21);
    send_word(mk_word(32'd1700, F_FRESH, '0, 0, 0), 21);
    send_word(mk_word(32'd1900, F_NEW | F_FRESH, '0, 0, 0), 21);

    // Ambiguous warm object latches the stricter values, then a warm box
    // below the score gate ends the cycle.
    send_word(mk_word(32'd2000, F_HIT, B_STRONG, 800, 500), 21);
    send_word(mk_word(32'd2100, F_HIT, B_CORE | B_STRONG, 800, 0), 21);
    send_word(mk_word(32'd2200, F_HIT | F_AGE, B_STRONG, 700, 500), 21);

    // Reflection rescued by score, red-orange and brightness, then not.
    w = mk_word(32'd3000, F_HIT, B_REFL | B_STRONG, 900, 0);
    w.red_orange      = 10'd300;
    w.brightness_diff = 12'd30;
    send_word(w, 21);
    w = mk_word(32'd3050, F_HIT, B_REFL | B_STRONG, 900, 0);
    w.red_orange = 10'd100;
    send_word(w, 21);

    // Finger passing with a separated skin region, then failing without it.
    send_word(mk_word(32'd3100, F_HIT, B_FINGER | B_STRONG | B_SEP, 950, 0), 21);
    send_word(mk_word(32'd3150, F_HIT, B_FINGER | B_STRONG, 950, 0), 21);

    // Tiny box that is skin by its ratios, then by its flag with a low score.
    w = mk_word(32'd3200, F_HIT, B_TINY | B_STRONG, 800, 0);
    w.candidate_skin   = 10'd400;
    w.surrounding_skin = 10'd100;
    send_word(w, 21);
    send_word(mk_word(32'd3250, F_HIT, B_TINY | B_SKIN | B_STRONG, 700, 0), 21);

    // Candidate ready alone shows the candidate status.
    send_word(mk_word(32'd3300, F_NEW | F_FRESH | F_CAND | F_AGE, '0, 0, 0), 21);

    // Hit timing across the wrap of the millisecond counter, then stale
    // words clear the cycle while the pending time is still reported.
    send_word(mk_word(32'hFFFF_FF00, F_HIT, B_CORE | B_STRONG, 500, 0), 21);
    send_word(mk_word(32'h0000_0100, F_HIT, B_CORE | B_STRONG, 500, 0), 21);
    send_word(mk_word(32'h0000_0180, F_NEW | F_DET | F_BOX, B_CORE | B_STRONG, 500, 0), 21);
    send_word(mk_word(32'h0000_0200, '0, '0, 0, 0), 21);
    drain();

    // Reset register values, with one long receiver hold-off.
    tick = 32'd4000;
    run_phase(170, 21, 74, 1'b1);
    drain();

    // Lowest values, hit minimums at one; a write past the registers is ignored.
    set_config(0, 0, 1, 0, 1, 0);
    reg_write(UnusedRegIdx, $urandom);
    run_phase(170, 21, 74, 1'b0);
    drain();

    // Highest register values, with the ambiguous score threshold at 1000.
    set_config(65535, 65535, 15, 65535, 15, 1000);
    run_phase(140, 74, 21, 1'b0);
    drain();

    // Ambiguous values below the normal ones, and a long run of clean hits
    // across the time wrap that takes the hit count to saturation.
    c = $urandom_range(150, 600);
    set_config(c, $urandom_range(50, 600), $urandom_range(1, 5), c / 2, 1,
               $urandom_range(500, 900));
    tick = 32'hFFFF_F000;
    rx_idle_pct <= 21;
    for (int unsigned i = 0; i < 270; i++) send_word(gen_word(BURST_STEADY), 74);
    run_phase(130, 74, 21, 1'b0);
    drain();

    // Typical settings with no idling on either side, and another hold-off.
    set_config($urandom_range(200, 500), $urandom_range(100, 500), $urandom_range(1, 4),
               $urandom_range(500, 1000), $urandom_range(2, 6), $urandom_range(700, 850));
    run_phase(140, 0, 0, 1'b1);
    drain();

    // Settings drawn from the full register ranges.
    set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 15),
               $urandom_range(65535), $urandom_range(1, 15), $urandom_range(1000));
    run_phase(130, 0, 0, 1'b0);
    drain();

    // A final wait catches any stray result word.
    repeat (8) @(posedge clk);

    $display("Covered %0d words under six register settings; %0d results, %0d mismatches.",
             sb.n_words, sb.n_results, sb.errors);
    $display("Results: %0d confirmed, %0d candidate, %0d warm, %0d at full hit count.",
             sb.n_confirmed, sb.n_candidate, sb.n_warm, sb.n_full);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/facg_pkg.sv
hdl/facg_cfg.sv
hdl/facg_gate.sv
hdl/facg_track.sv
hdl/fire_alarm_confirm_gate_core.sv
test/facg_tb_pkg.sv
test/tb_fire_alarm_confirm_gate_core.sv
